// File: hw/rtl/brw_pkg.sv
// ----------------------------------------------------------------------------
// brw_pkg: shared types and constants of the boot recovery watchdog
// Register indexes, reset values, outcome codes and the beat structs.
// ----------------------------------------------------------------------------
package brw_pkg;

  // register indexes on the config port
  localparam logic [2:0] CFG_BOOT_LIMIT     = 3'd0;
  localparam logic [2:0] CFG_SHUTDOWN_LIMIT = 3'd1;
  localparam logic [2:0] CFG_PAUSE          = 3'd2;
  localparam logic [2:0] CFG_PULSE_INTERVAL = 3'd3;
  localparam logic [2:0] CFG_BRINGUP_LIMIT  = 3'd4;

  // register reset values, in milliseconds
  localparam logic [15:0] BOOT_LIMIT_RST     = 16'd3000;
  localparam logic [15:0] SHUTDOWN_LIMIT_RST = 16'd20000;
  localparam logic [15:0] PAUSE_RST          = 16'd500;
  localparam logic [15:0] PULSE_INTERVAL_RST = 16'd500;
  localparam logic [15:0] BRINGUP_LIMIT_RST  = 16'd10000;

  // outcome codes
  localparam logic [2:0] OUT_NONE      = 3'd0;
  localparam logic [2:0] OUT_SUCCESS   = 3'd1;
  localparam logic [2:0] OUT_RECOVERED = 3'd2;
  localparam logic [2:0] OUT_SHUT_TO   = 3'd3;
  localparam logic [2:0] OUT_BRING_TO  = 3'd4;

  typedef struct packed {
    logic [15:0] boot_limit_ms;
    logic [15:0] shutdown_limit_ms;
    logic [15:0] pause_ms;
    logic [15:0] pulse_interval_ms;
    logic [15:0] bringup_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic action;
    logic boot_ok;
    logic reboot_request;
    logic shutdown_ok;
    logic bringup_ok;
  } item_t;

  typedef struct packed {
    logic       send_shutdown;
    logic       send_power_switch;
    logic       clear_shutdown_flag;
    logic       clear_bringup_flag;
    logic       busy_res;
    logic [2:0] outcome;
  } result_t;

endpackage

// File: hw/rtl/brw_cfg.sv
// ----------------------------------------------------------------------------
// brw_cfg: limit registers
// Five 16-bit timing registers, written through a plain write port.
// ----------------------------------------------------------------------------
module brw_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  output brw_pkg::cfg_t       cfg_o
);

  brw_pkg::cfg_t cfg_q, cfg_d;

  // decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        brw_pkg::CFG_BOOT_LIMIT:     cfg_d.boot_limit_ms     = cfg_wdata_i;
        brw_pkg::CFG_SHUTDOWN_LIMIT: cfg_d.shutdown_limit_ms = cfg_wdata_i;
        brw_pkg::CFG_PAUSE:          cfg_d.pause_ms          = cfg_wdata_i;
        brw_pkg::CFG_PULSE_INTERVAL: cfg_d.pulse_interval_ms = cfg_wdata_i;
        brw_pkg::CFG_BRINGUP_LIMIT:  cfg_d.bringup_limit_ms  = cfg_wdata_i;
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.boot_limit_ms     <= brw_pkg::BOOT_LIMIT_RST;
      cfg_q.shutdown_limit_ms <= brw_pkg::SHUTDOWN_LIMIT_RST;
      cfg_q.pause_ms          <= brw_pkg::PAUSE_RST;
      cfg_q.pulse_interval_ms <= brw_pkg::PULSE_INTERVAL_RST;
      cfg_q.bringup_limit_ms  <= brw_pkg::BRINGUP_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/brw_fsm.sv
// ----------------------------------------------------------------------------
// brw_fsm: supervision sequencer
// Phase and counters, advanced once per accepted beat; the result of the
// beat is produced combinationally for the output register.
// ----------------------------------------------------------------------------
module brw_fsm (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  brw_pkg::item_t    item_i,
  input  brw_pkg::cfg_t     cfg_i,
  output brw_pkg::result_t  res_o
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_BOOT  = 3'd1;
  localparam logic [2:0] PH_SHUT  = 3'd2;
  localparam logic [2:0] PH_PAUSE = 3'd3;
  localparam logic [2:0] PH_BRING = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [15:0] since_pulse_q, since_pulse_d;
  logic        pulse_seen_q, pulse_seen_d;
  logic [15:0] elapsed_inc, since_inc;

  // saturating increments
  assign elapsed_inc = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;
  assign since_inc   = (since_pulse_q == 16'hFFFF) ? since_pulse_q
                                                   : since_pulse_q + 16'd1;

  // next state and result of one beat
  always_comb begin
    phase_d       = phase_q;
    elapsed_d     = elapsed_q;
    since_pulse_d = since_pulse_q;
    pulse_seen_d  = pulse_seen_q;
    res_o         = '0;
    res_o.outcome = brw_pkg::OUT_NONE;
    if (item_i.action) begin
      phase_d       = PH_BOOT;
      elapsed_d     = '0;
      since_pulse_d = '0;
      pulse_seen_d  = 1'b0;
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
          phase_d = PH_IDLE;
        end
        PH_BOOT: begin
          elapsed_d = elapsed_inc;
          if (item_i.boot_ok) begin
            res_o.outcome = brw_pkg::OUT_SUCCESS;
            phase_d       = PH_IDLE;
          end else if (elapsed_inc > cfg_i.boot_limit_ms || item_i.reboot_request) begin
            res_o.send_shutdown       = 1'b1;
            res_o.clear_shutdown_flag = 1'b1;
            phase_d                   = PH_SHUT;
            elapsed_d                 = '0;
          end
        end
        PH_SHUT: begin
          elapsed_d = elapsed_inc;
          if (item_i.shutdown_ok) begin
            res_o.clear_bringup_flag = 1'b1;
            elapsed_d                = '0;
            if (cfg_i.pause_ms == 16'd0) begin
              phase_d       = PH_BRING;
              since_pulse_d = '0;
              pulse_seen_d  = 1'b0;
            end else begin
              phase_d = PH_PAUSE;
            end
          end else if (elapsed_inc > cfg_i.shutdown_limit_ms) begin
            res_o.outcome = brw_pkg::OUT_SHUT_TO;
            phase_d       = PH_IDLE;
          end
        end
        PH_PAUSE: begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= cfg_i.pause_ms) begin
            phase_d       = PH_BRING;
            elapsed_d     = '0;
            since_pulse_d = '0;
            pulse_seen_d  = 1'b0;
          end
        end
        PH_BRING: begin
          elapsed_d     = elapsed_inc;
          since_pulse_d = since_inc;
          if (item_i.bringup_ok) begin
            res_o.outcome = brw_pkg::OUT_RECOVERED;
            phase_d       = PH_IDLE;
          end else begin
            if (!pulse_seen_q || since_inc > cfg_i.pulse_interval_ms) begin
              res_o.send_power_switch = 1'b1;
              since_pulse_d           = '0;
              pulse_seen_d            = 1'b1;
            end
            if (elapsed_inc > cfg_i.bringup_limit_ms) begin
              res_o.outcome = brw_pkg::OUT_BRING_TO;
              phase_d       = PH_IDLE;
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
    res_o.busy_res = (phase_d != PH_IDLE);
  end

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      elapsed_q     <= '0;
      since_pulse_q <= '0;
      pulse_seen_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q       <= phase_d;
      elapsed_q     <= elapsed_d;
      since_pulse_q <= since_pulse_d;
      pulse_seen_q  <= pulse_seen_d;
    end
  end

  // a start beat always lands in boot wait with cleared counters
  a_start_boot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && item_i.action |=> phase_q == PH_BOOT && elapsed_q == 16'd0)
    else $error("start beat did not arm boot wait");

  // a tick while idle leaves the sequencer idle
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !item_i.action && phase_q == PH_IDLE |=> phase_q == PH_IDLE)
    else $error("idle tick left idle");

  // pulse spacing counter only runs in bringup
  a_since_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_BRING && phase_q != PH_IDLE |-> since_pulse_q == 16'd0)
    else $error("pulse counter running outside bringup");

endmodule

// File: hw/rtl/brw_out.sv
// ----------------------------------------------------------------------------
// brw_out: result register
// Holds one result beat; a new beat loads while the held one is taken.
// ----------------------------------------------------------------------------
module brw_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  brw_pkg::result_t  res_i,
  input  logic              out_stall_i,
  output logic              full_stall_o,
  output logic              out_valid_o,
  output brw_pkg::result_t  res_o
);

  logic             valid_q, valid_d;
  brw_pkg::result_t res_q;

  // upstream waits only when the held beat is not being taken
  assign full_stall_o = valid_q && out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  // a finished sequence is never reported as still running
  a_outcome_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && res_q.outcome != brw_pkg::OUT_NONE |-> !res_q.busy_res)
    else $error("outcome with busy set");

  // shutdown command always travels with its flag clear
  a_sd_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> res_q.send_shutdown == res_q.clear_shutdown_flag)
    else $error("shutdown pulse without flag clear");

  // a load never happens while the held beat is stuck
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !(valid_q && out_stall_i))
    else $error("result register overwritten");

endmodule

// File: hw/rtl/boot_recovery_watchdog.sv
// ----------------------------------------------------------------------------
// boot_recovery_watchdog: boot supervisor with shutdown and power recovery
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i / in_stall_o  action, boot_ok, reboot_request,
//                                                shutdown_ok, bringup_ok
//   out      source     out_valid_o / out_stall_i send_shutdown, send_power_switch,
//                                                clear_shutdown_flag,
//                                                clear_bringup_flag, busy_res, outcome
//   cfg      sink       cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// One beat in per cycle while in_stall_o is low; its result appears in the output
// register in the cycle after acceptance. The phase and counter update is a
// single compare and increment step.
// Reset clears the sequencer to idle, empties the output register and loads
// the register defaults. A stalled output blocks the input only while the
// held result is not taken; otherwise input and output move every cycle.
// ----------------------------------------------------------------------------
module boot_recovery_watchdog (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic        boot_ok_i,
  input  logic        reboot_request_i,
  input  logic        shutdown_ok_i,
  input  logic        bringup_ok_i,
  // result beats
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        send_shutdown_o,
  output logic        send_power_switch_o,
  output logic        clear_shutdown_flag_o,
  output logic        clear_bringup_flag_o,
  output logic        busy_res_o,
  output logic [2:0]  outcome_o,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  brw_pkg::cfg_t    cfg;
  brw_pkg::item_t   item;
  brw_pkg::result_t res_next, res_held;
  logic             accept;

  // gather the input beat
  assign item.action         = action_i;
  assign item.boot_ok        = boot_ok_i;
  assign item.reboot_request = reboot_request_i;
  assign item.shutdown_ok    = shutdown_ok_i;
  assign item.bringup_ok     = bringup_ok_i;

  assign accept = in_valid_i && !in_stall_o;

  brw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  brw_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .cfg_i    (cfg),
    .res_o    (res_next)
  );

  brw_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .res_i        (res_next),
    .out_stall_i  (out_stall_i),
    .full_stall_o (in_stall_o),
    .out_valid_o  (out_valid_o),
    .res_o        (res_held)
  );

  // spread the result beat onto its ports
  assign send_shutdown_o       = res_held.send_shutdown;
  assign send_power_switch_o   = res_held.send_power_switch;
  assign clear_shutdown_flag_o = res_held.clear_shutdown_flag;
  assign clear_bringup_flag_o  = res_held.clear_bringup_flag;
  assign busy_res_o            = res_held.busy_res;
  assign outcome_o             = res_held.outcome;

endmodule
